@@ src/amptg_pkg.sv @@
`timescale 1ns / 1ps

package amptg_pkg;

    // Width of the fire mask result field
    localparam int MASK_W = 11;

    // Request type codes
    localparam logic REQ_SETUP = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP_DIV,
        ST_TICK_CHECK,
        ST_TICK_DIV,
        ST_FINISH
    } state_t;

endpackage

@@ src/amptg_rem.sv @@
`timescale 1ns / 1ps

// Restoring remainder unit: dividend modulo divisor, one dividend bit per cycle.
module amptg_rem #(
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [TIME_BITS-1:0] dividend,
    input  logic [31:0]          divisor,
    output logic                 done,
    output logic [31:0]          remainder
);

    localparam int STEP_W = $clog2(TIME_BITS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [TIME_BITS-1:0] dvd_reg;
    logic [31:0]          dsr_reg;
    logic [32:0]          rem_reg;
    logic [32:0]          shifted;
    logic [32:0]          rem_next;

    // Shift in the next dividend bit and subtract the divisor if it fits
    always_comb begin
        shifted = {rem_reg[31:0], dvd_reg[TIME_BITS-1]};
        if (shifted >= {1'b0, dsr_reg}) begin
            rem_next = shifted - {1'b0, dsr_reg};
        end else begin
            rem_next = shifted;
        end
    end

    // Control: load on start, run TIME_BITS steps, pulse done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(TIME_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[TIME_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[31:0];

endmodule

@@ src/aligned_multi_period_tick_generator.sv @@
`timescale 1ns / 1ps

// Aligned multi-period tick generator. Each channel keeps a period and a mark
// aligned to a multiple of that period. A setup item (req_type 0) stores a
// channel's period and aligns its mark to now; a tick item (req_type 1) fires
// every enabled channel whose period has elapsed since its mark, realigns it,
// and returns the fire mask. Every item returns one mask (zero for setup).
// Timing: one remainder unit does every alignment, one dividend bit per cycle.
// A setup with a zero period or a bad channel index skips the division. A
// tick checks the channels in turn and runs a division for each one that
// fires. The block takes one item at a time; ready is high only while the
// sequencer is idle, and the result waits in an output register so the next
// item can be taken before it is collected.
module aligned_multi_period_tick_generator #(
    parameter int CHANNELS  = 11,
    parameter int TIME_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_req_type,
    input  logic [31:0]                s_now_seconds,
    input  logic [3:0]                 s_channel_index,
    input  logic [31:0]                s_period_seconds,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [amptg_pkg::MASK_W-1:0] m_fire_mask
);

    import amptg_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    state_t               state_reg, state_next;
    logic [CH_W-1:0]      cnt_reg, cnt_next;
    logic [CH_W-1:0]      idx_reg, idx_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [MASK_W-1:0]    mask_reg, mask_next;
    logic                 m_valid_reg;
    logic [MASK_W-1:0]    m_mask_reg;

    logic [31:0]          period_table [CHANNELS];
    logic [TIME_BITS-1:0] mark_table [CHANNELS];

    logic                 in_xfer;
    logic [63:0]          now_wide;
    logic [TIME_BITS-1:0] now_in;
    logic [5:0]           idx_wide;
    logic                 idx_ok;
    logic [CH_W-1:0]      idx_in;
    logic [31:0]          cur_p;
    logic [TIME_BITS-1:0] cur_m;
    logic [TIME_BITS-1:0] elapsed;
    logic                 fire;
    logic                 last;
    logic [63:0]          rem_wide;
    logic [TIME_BITS-1:0] new_mark;

    logic                 div_start;
    logic                 div_done;
    logic [TIME_BITS-1:0] div_dvd;
    logic [31:0]          div_dsr;
    logic [31:0]          div_rem;

    logic                 per_we;
    logic                 mark_we;
    logic [CH_W-1:0]      wr_idx;
    logic [TIME_BITS-1:0] wr_mark;
    logic                 out_load;

    // Decode the incoming transfer
    assign in_xfer  = s_valid && s_ready;
    assign now_wide = {32'd0, s_now_seconds};
    assign now_in   = now_wide[TIME_BITS-1:0];
    assign idx_wide = {2'b00, s_channel_index};
    assign idx_ok   = idx_wide < 6'(CHANNELS);
    assign idx_in   = idx_wide[CH_W-1:0];

    // Check the channel under the scan counter
    assign cur_p   = period_table[cnt_reg];
    assign cur_m   = mark_table[cnt_reg];
    assign elapsed = now_reg - cur_m;
    assign fire    = (cur_p != 32'd0) && (now_reg >= cur_m)
                     && (64'(elapsed) >= {32'd0, cur_p});
    assign last    = cnt_reg == CH_W'(CHANNELS - 1);

    // Aligned mark: now minus now modulo period
    assign rem_wide = {32'd0, div_rem};
    assign new_mark = now_reg - rem_wide[TIME_BITS-1:0];

    // Feed the remainder unit from the ports on setup, from the held time and the period table on tick
    assign div_dvd = (state_reg == ST_IDLE) ? now_in : now_reg;
    assign div_dsr = (state_reg == ST_IDLE) ? s_period_seconds : cur_p;

    amptg_rem #(
        .TIME_BITS(TIME_BITS)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .remainder(div_rem)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_req_type == REQ_TICK) begin
                        state_next = ST_TICK_CHECK;
                    end else if (idx_ok && (s_period_seconds != 32'd0)) begin
                        state_next = ST_SETUP_DIV;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SETUP_DIV: begin
                if (div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_TICK_CHECK: begin
                if (fire) begin
                    state_next = ST_TICK_DIV;
                end else if (last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_TICK_DIV: begin
                if (div_done) begin
                    state_next = last ? ST_FINISH : ST_TICK_CHECK;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs and datapath next values
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        per_we    = 1'b0;
        mark_we   = 1'b0;
        wr_idx    = idx_reg;
        wr_mark   = new_mark;
        out_load  = 1'b0;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        now_next  = now_reg;
        mask_next = mask_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (in_xfer) begin
                    now_next  = now_in;
                    idx_next  = idx_in;
                    cnt_next  = '0;
                    mask_next = '0;
                    if ((s_req_type == REQ_SETUP) && idx_ok) begin
                        per_we = 1'b1;
                        wr_idx = idx_in;
                        if (s_period_seconds == 32'd0) begin
                            mark_we = 1'b1;
                            wr_mark = now_in;
                        end else begin
                            div_start = 1'b1;
                        end
                    end
                end
            end
            ST_SETUP_DIV: begin
                mark_we = div_done;
            end
            ST_TICK_CHECK: begin
                if (fire) begin
                    div_start = 1'b1;
                    for (int b = 0; b < MASK_W; b++) begin
                        if ((b < CHANNELS) && (cnt_reg == CH_W'(b))) begin
                            mask_next[b] = 1'b1;
                        end
                    end
                end else if (!last) begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_TICK_DIV: begin
                wr_idx = cnt_reg;
                if (div_done) begin
                    mark_we = 1'b1;
                    if (!last) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: ;
        endcase
    end

    // Control registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold item context and the result payload
    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        now_reg  <= now_next;
        mask_reg <= mask_next;
        if (out_load) begin
            m_mask_reg <= mask_reg;
        end
    end

    // Channel tables, cleared to disabled at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                period_table[i] <= '0;
                mark_table[i]   <= '0;
            end
        end else begin
            if (per_we) begin
                period_table[wr_idx] <= s_period_seconds;
            end
            if (mark_we) begin
                mark_table[wr_idx] <= wr_mark;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_fire_mask = m_mask_reg;

endmodule

@@ src/amptg_checker.sv @@
`timescale 1ns / 1ps

module amptg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [10:0] m_fire_mask
);

    logic [1:0] open_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;

    // Count items taken whose mask is not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else begin
            open_reg <= open_reg + {1'b0, in_xfer} - {1'b0, out_xfer};
        end
    end

    // A held result keeps its mask
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fire_mask))
        else $error("result changed while stalled");

    // One item at a time: ready drops after an input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_ready)
        else $error("ready stayed high after input transfer");

    // No result without an item behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> open_reg != 2'd0)
        else $error("result with no item outstanding");

    // At most one finished item waits while another is in work
    assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg != 2'd3)
        else $error("too many items outstanding");

endmodule

bind aligned_multi_period_tick_generator amptg_checker u_amptg_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_fire_mask(m_fire_mask)
);
